/* sv/ftt_pkg.sv */
// Shared types and constants for the flow table tracker.
`default_nettype none
package ftt_pkg;
    // table depth, a power of two so the home slot is the low key bits
    localparam int TABLE_SIZE = 1024;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] THRESHOLD_RESET = 16'd16;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_REPORT  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // classified packet handed from front to back
    typedef struct packed {
        logic        ignored;
        logic [31:0] key;
        logic [31:0] src_ip;
    } ftt_job_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic        is_forward;
        logic        new_flow;
        logic [15:0] total_count;
        logic [15:0] forward_count;
        logic [15:0] backward_count;
    } ftt_result_t;

    function automatic logic [15:0] count_up(input logic [15:0] v);
        count_up = (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
    endfunction
endpackage
`default_nettype wire

/* sv/flow_table_tracker.sv */
// Flow table tracker top level: five-tuple hashing into a linear-probe table.
// s_axis: one packet header word; m_axis: one result word per header.
// cfg: write of packet_threshold (reset 16), only while the block is idle.
// A header passes a two-stage key pipeline, a four-entry queue, then the
// table engine, which accepts it, visits each probed slot through address,
// memory read and compare-and-write states, then outputs the result. A
// header whose home slot matches or is empty needs one probe; each miss
// moves to the next slot, a full table is reported once every slot is
// probed, and an ignored protocol goes straight from accept to output.
// Reset (aresetn low, synchronous) sets the threshold to 16 and starts a
// clearing pass over every table slot; headers wait in the front end and
// queue until it ends. A stalled m_axis holds its word; the engine finishes
// the next header into a pending register and waits, while the queue and
// front end keep taking headers until they fill.
`default_nettype none
module flow_table_tracker
    import ftt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // src_ip[31:0], dst_ip[63:32], src_port[79:64], dst_port[95:80], protocol[103:96]
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], slot[11:2], is_forward[12], new_flow[13], total[29:14],
    // forward[45:30], backward[61:46], zero[63:62]
    output logic [63:0]       m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);
    logic [15:0] thr_reg;
    logic        fj_valid, fj_ready, qj_valid, qj_ready;
    ftt_job_t    fj, qj;
    ftt_result_t r;

    assign cfg_ready = 1'b1;
    // hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= THRESHOLD_RESET;
        else if (cfg_valid) thr_reg <= cfg_data;
    end

    ftt_front u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .src_ip(s_axis_tdata[31:0]), .dst_ip(s_axis_tdata[63:32]),
        .src_port(s_axis_tdata[79:64]), .dst_port(s_axis_tdata[95:80]),
        .protocol(s_axis_tdata[103:96]),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    ftt_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj)
    );

    ftt_engine u_engine (
        .aclk, .aresetn, .threshold(thr_reg),
        .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
    );

    assign m_axis_tdata = {2'b00, r.backward_count, r.forward_count, r.total_count,
                           r.new_flow, r.is_forward, r.slot, r.status};
endmodule
`default_nettype wire

/* sv/ftt_front.sv */
// Front end: accepts headers, computes the flow key over two stages.
`default_nettype none
module ftt_front
    import ftt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic [7:0]  protocol,
    output logic             job_valid,
    input  wire logic        job_ready,
    output ftt_job_t         job
);
    // reciprocal of 313 for 32-bit quotients: ceil(2^41/313)
    localparam logic [32:0] RECIP = 33'd7025633405;

    logic        s1_valid_reg;
    logic [64:0] qs_reg, qd_reg;
    logic [31:0] part_reg, src_reg;
    logic        ign_reg;
    logic        s2_valid_reg;
    ftt_job_t    job_reg;

    logic s1_adv;
    assign job_valid = s2_valid_reg;
    assign job       = job_reg;
    assign s1_adv    = !s2_valid_reg || job_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;

    logic [31:0] qs, qd, part;
    always_comb begin
        qs = 32'(qs_reg >> 41);
        qd = 32'(qd_reg >> 41);
        part = 32'(src_port) * 32'd3 + 32'(dst_port) * 32'd3 + 32'(protocol) * 32'd7;
    end

    // stage one multiplies by the reciprocal and forms the port and protocol term, stage two sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
                if (in_valid) begin
                    qs_reg   <= 65'(src_ip) * 65'(RECIP);
                    qd_reg   <= 65'(dst_ip) * 65'(RECIP);
                    part_reg <= part;
                    src_reg  <= src_ip;
                    ign_reg  <= (protocol != PROTO_TCP) && (protocol != PROTO_UDP);
                end
            end
            if (s1_adv) begin
                s2_valid_reg <= s1_valid_reg;
                if (s1_valid_reg) begin
                    job_reg <= '{ignored: ign_reg, key: qs + qd + part_reg,
                                 src_ip: src_reg};
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/ftt_queue.sv */
// Short queue between the front end and the table engine.
`default_nettype none
module ftt_queue
    import ftt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  wire ftt_job_t wr_data,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output ftt_job_t      rd_data
);
    ftt_job_t   mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4) else $error("queue overflow");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 3'd1) else $error("queue count");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 3'd0) |-> !rd) else $error("read empty");
`endif
endmodule
`default_nettype wire

/* sv/ftt_engine.sv */
// Back end: probes the table, updates counts and registers the result word.
`default_nettype none
module ftt_engine
    import ftt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] threshold,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire ftt_job_t    job,
    output logic             res_valid,
    input  wire logic        res_ready,
    output ftt_result_t      res
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam logic [AW:0] LAST = (AW+1)'(TABLE_SIZE - 1);
    localparam logic [AW:0] SIZE = (AW+1)'(TABLE_SIZE);

    typedef struct packed {
        logic        v;
        logic [31:0] key;
        logic [31:0] src;
        logic [15:0] tot;
        logic [15:0] fwd;
        logic [15:0] bwd;
    } entry_t;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_CHECK, S_OUT} state_t;

    entry_t          mem [TABLE_SIZE];
    entry_t          rd_reg;
    logic            rv_reg;
    state_t          state_reg;
    logic [AW-1:0]   pos_reg;
    logic [AW:0]     tries_reg;
    logic [31:0]     key_reg, src_reg;
    logic            res_valid_reg;
    ftt_result_t     res_reg;
    ftt_result_t     out_reg;
    logic            out_load;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;

    assign job_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_load  = (state_reg == S_OUT) && (!res_valid_reg || res_ready);

    // table memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[pos_reg];
    end

    // compute the update for a hit or a new entry
    logic        fwd, hit;
    entry_t      upd, base;
    logic [15:0] t;
    always_comb begin
        hit  = key_reg == rd_reg.key;
        base = rv_reg ? rd_reg : entry_t'{v: 1'b1, key: key_reg, src: src_reg,
                                          tot: 16'd0, fwd: 16'd0, bwd: 16'd0};
        fwd  = base.src == src_reg;
        t    = count_up(base.tot);
        upd  = base;
        upd.tot = t;
        if (fwd) upd.fwd = count_up(base.fwd);
        else     upd.bwd = count_up(base.bwd);
        wr_en   = ((state_reg == S_CHECK) && (!rv_reg || hit)) || (state_reg == S_CLEAR);
        wr_addr = pos_reg;
        wr_data = upd;
        if (t == threshold) begin
            wr_data.tot = '0; wr_data.fwd = '0; wr_data.bwd = '0;
        end
        // clear the valid marks one slot per cycle after reset
        if (state_reg == S_CLEAR) wr_data = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            res_valid_reg <= 1'b0;
            pos_reg       <= '0;
            tries_reg     <= '0;
        end else begin
            // move the pending word to the output register once it is free
            if (out_load) begin
                res_reg       <= out_reg;
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    pos_reg <= pos_reg + 1'b1;
                    if ((AW+1)'(pos_reg) == LAST) state_reg <= S_IDLE;
                end
                S_IDLE: if (job_valid) begin
                    key_reg   <= job.key;
                    src_reg   <= job.src_ip;
                    pos_reg   <= job.key[AW-1:0];
                    tries_reg <= '0;
                    if (job.ignored) begin
                        out_reg   <= '{status: ST_IGNORED, default: '0};
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_WAIT;
                S_WAIT: begin
                    rv_reg    <= rd_reg.v;
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (!rv_reg || hit) begin
                        out_reg <= '{status: (t == threshold) ? ST_REPORT : ST_COUNTED,
                                     slot: 10'(pos_reg),
                                     is_forward: fwd,
                                     new_flow: !rv_reg,
                                     total_count: upd.tot,
                                     forward_count: upd.fwd,
                                     backward_count: upd.bwd};
                        state_reg <= S_OUT;
                    end else if (tries_reg == LAST) begin
                        out_reg   <= '{status: ST_FULL, default: '0};
                        state_reg <= S_OUT;
                    end else begin
                        tries_reg <= tries_reg + 1'b1;
                        pos_reg   <= ((AW+1)'(pos_reg) == LAST) ? '0 : pos_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_OUT: if (out_load) begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_tries: assert property (@(posedge aclk) disable iff (!aresetn)
        tries_reg < SIZE || state_reg == S_IDLE) else $error("probe overrun");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !res_ready) |=> res_valid_reg) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !job_ready) else $error("ready while busy");
`endif
endmodule
`default_nettype wire
